/* rtl/rgb_led_chain_serializer_top_macros.svh */
// assertion macros for the rgb led chain serializer
// no dependencies; taken in by the top level with an include
`ifndef RGB_LED_CHAIN_SERIALIZER_TOP_MACROS_SVH
`define RGB_LED_CHAIN_SERIALIZER_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define RLCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlcs assertion failed");
// next-cycle implication, checked out of reset
`define RLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlcs assertion failed");
`else
`define RLCS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rlcs_pkg.sv */
// shared types and constants for the rgb led chain serializer
// no dependencies; used by rlcs_engine and the top level
package rlcs_pkg;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_TOGGLE = 2'd2
    } kind_t;

    // colour byte slots of the serial cycle
    typedef enum logic [1:0] {
        SLOT_RED   = 2'd0,
        SLOT_GREEN = 2'd1,
        SLOT_BLUE  = 2'd2,
        SLOT_SKIP  = 2'd3
    } slot_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LED_COUNT  = 3'd0,
        CFG_BIT_PERIOD = 3'd1,
        CFG_ONE_HIGH   = 3'd2,
        CFG_ZERO_HIGH  = 3'd3,
        CFG_LATCH_GAP  = 3'd4
    } cfg_idx_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COLOUR_W    = 8;

    localparam logic [7:0]  LED_COUNT_RESET  = 8'd12;
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd30;
    localparam logic [15:0] ONE_HIGH_RESET   = 16'd21;
    localparam logic [15:0] ZERO_HIGH_RESET  = 16'd7;
    localparam logic [15:0] LATCH_GAP_RESET  = 16'd7200;
    localparam logic [7:0]  RED_RESET        = 8'hFF;
    localparam logic [7:0]  GREEN_RESET      = 8'h00;
    localparam logic [7:0]  BLUE_RESET       = 8'h00;

    typedef struct packed {
        logic [7:0]  led_count;
        logic [15:0] bit_period_ticks;
        logic [15:0] one_high_ticks;
        logic [15:0] zero_high_ticks;
        logic [15:0] latch_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic power_enable_n;
        logic line_level;
    } result_t;

endpackage

/* rtl/rlcs_engine.sv */
// frame timing and colour state of the rgb led chain serializer
// depends on rlcs_pkg; instantiated by rgb_led_chain_serializer_top
module rlcs_engine #(
    parameter int TICK_COUNTER_WIDTH = 16,
    parameter int BITS_PER_LED       = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_accept,
    input  rlcs_pkg::kind_t      req_kind,
    input  logic [7:0]           req_rx_byte,
    input  rlcs_pkg::cfg_t       cfg,
    output rlcs_pkg::result_t    result
);
    import rlcs_pkg::*;

    localparam int BIT_POS_W = $clog2(BITS_PER_LED);
    localparam int CMP_W     = (TICK_COUNTER_WIDTH > 16 ? TICK_COUNTER_WIDTH : 16) + 1;

    logic [COLOUR_W-1:0]           red_reg, red_next;
    logic [COLOUR_W-1:0]           green_reg, green_next;
    logic [COLOUR_W-1:0]           blue_reg, blue_next;
    slot_t                         slot_reg, slot_next;
    logic                          lamp_on_reg, lamp_on_next;
    logic [7:0]                    led_pos_reg, led_pos_next;
    logic [BIT_POS_W-1:0]          bit_pos_reg, bit_pos_next;
    logic [TICK_COUNTER_WIDTH-1:0] tick_reg, tick_next;
    logic                          gap_reg, gap_next;
    logic                          frame_reg, frame_next;
    logic [BITS_PER_LED-1:0]       shift_reg, shift_next;

    logic [CMP_W-1:0]        tick_inc;
    logic [15:0]             period_raw;
    logic [15:0]             period_eff;
    logic [7:0]              count_eff;
    logic                    period_done;
    logic [15:0]             high_cur;
    logic                    lvl_cur;
    logic                    lvl_inc;
    logic [BITS_PER_LED-1:0] colour_word;
    logic                    tick_cleared;
    logic                    tick_stepped;
    logic                    new_top;
    logic                    lvl_start;

    // counter comparisons, all against the current state so they run in parallel
    assign period_raw  = gap_reg ? cfg.latch_gap_ticks : cfg.bit_period_ticks;
    assign period_eff  = (period_raw == '0) ? 16'd1 : period_raw;
    assign count_eff   = (cfg.led_count == '0) ? 8'd1 : cfg.led_count;
    assign tick_inc    = CMP_W'(tick_reg) + CMP_W'(1);
    assign period_done = (tick_reg == '1) || (tick_inc >= CMP_W'(period_eff));
    assign high_cur    = shift_reg[BITS_PER_LED-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign lvl_cur     = CMP_W'(tick_reg) < CMP_W'(high_cur);
    assign lvl_inc     = tick_inc < CMP_W'(high_cur);
    assign colour_word = BITS_PER_LED'({green_reg, red_reg, blue_reg}) << (BITS_PER_LED - 24);

    always_comb begin
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        slot_next    = slot_reg;
        lamp_on_next = lamp_on_reg;
        led_pos_next = led_pos_reg;
        bit_pos_next = bit_pos_reg;
        tick_next    = tick_reg;
        gap_next     = gap_reg;
        frame_next   = frame_reg;
        shift_next   = shift_reg;
        tick_cleared = 1'b0;
        tick_stepped = 1'b0;
        if (req_accept) begin
            unique case (req_kind)
                KIND_TICK: begin
                    if (frame_reg) begin
                        if (!period_done) begin
                            tick_next    = TICK_COUNTER_WIDTH'(tick_inc);
                            tick_stepped = 1'b1;
                        end else if (gap_reg) begin
                            gap_next     = 1'b0;
                            frame_next   = 1'b0;
                            tick_next    = '0;
                            tick_cleared = 1'b1;
                        end else begin
                            tick_next    = '0;
                            tick_cleared = 1'b1;
                            if (bit_pos_reg != BIT_POS_W'(BITS_PER_LED - 1)) begin
                                bit_pos_next = bit_pos_reg + BIT_POS_W'(1);
                                shift_next   = shift_reg << 1;
                            end else begin
                                bit_pos_next = '0;
                                if ({1'b0, led_pos_reg} + 9'd1 < {1'b0, count_eff}) begin
                                    led_pos_next = led_pos_reg + 8'd1;
                                    shift_next   = colour_word;
                                end else begin
                                    led_pos_next = '0;
                                    gap_next     = 1'b1;
                                end
                            end
                        end
                    end else if (lamp_on_reg) begin
                        frame_next   = 1'b1;
                        gap_next     = 1'b0;
                        led_pos_next = '0;
                        bit_pos_next = '0;
                        tick_next    = '0;
                        tick_cleared = 1'b1;
                        shift_next   = colour_word;
                    end
                end
                KIND_BYTE: begin
                    unique case (slot_reg)
                        SLOT_RED: begin
                            red_next  = req_rx_byte;
                            slot_next = SLOT_GREEN;
                        end
                        SLOT_GREEN: begin
                            green_next = req_rx_byte;
                            slot_next  = SLOT_BLUE;
                        end
                        SLOT_BLUE: begin
                            blue_next = req_rx_byte;
                            slot_next = SLOT_SKIP;
                        end
                        SLOT_SKIP: begin
                            slot_next = SLOT_RED;
                        end
                    endcase
                end
                KIND_TOGGLE: begin
                    lamp_on_next = !lamp_on_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // a freshly cleared counter shows high whenever the new bit has any high time
    assign new_top   = shift_next[BITS_PER_LED-1];
    assign lvl_start = new_top ? (cfg.one_high_ticks != '0) : (cfg.zero_high_ticks != '0);

    always_comb begin
        result.power_enable_n = !(lamp_on_next || frame_next);
        priority if (!frame_next || gap_next) begin
            result.line_level = 1'b0;
        end else if (tick_cleared) begin
            result.line_level = lvl_start;
        end else if (tick_stepped) begin
            result.line_level = lvl_inc;
        end else begin
            result.line_level = lvl_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg     <= RED_RESET;
            green_reg   <= GREEN_RESET;
            blue_reg    <= BLUE_RESET;
            slot_reg    <= SLOT_RED;
            lamp_on_reg <= 1'b0;
            led_pos_reg <= '0;
            bit_pos_reg <= '0;
            tick_reg    <= '0;
            gap_reg     <= 1'b0;
            frame_reg   <= 1'b0;
            shift_reg   <= '0;
        end else begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            slot_reg    <= slot_next;
            lamp_on_reg <= lamp_on_next;
            led_pos_reg <= led_pos_next;
            bit_pos_reg <= bit_pos_next;
            tick_reg    <= tick_next;
            gap_reg     <= gap_next;
            frame_reg   <= frame_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

/* rtl/rgb_led_chain_serializer_top.sv */
// top level of the rgb led chain serializer: stream ports, config registers, result register
// depends on rlcs_pkg, rlcs_engine and rgb_led_chain_serializer_top_macros.svh
`include "rgb_led_chain_serializer_top_macros.svh"

// Drives a one-wire addressable RGB LED chain from a stream of requests. Each request
// is a clock tick, a received serial byte or a lamp toggle (kind on s_tuser), and each
// one gives exactly one result: the data line level and the active-low power enable
// after that request. Serial bytes fill red, green, blue in turn and a fourth byte is
// dropped, restarting the cycle; the colour resets to full red. While the lamp is on,
// tick requests run frames of led_count LEDs, 24 bits each sent G,R,B msb first, each
// bit bit_period_ticks long with a high time of one_high_ticks or zero_high_ticks,
// followed by a low latch gap of latch_gap_ticks. A frame in flight finishes after the
// lamp is switched off. One request is taken every clock unless a result waits unread;
// each result is registered in the output register, and a waiting result does not stop
// the next request as long as the consumer takes it in the same cycle. Config registers
// take effect at once and are meant to be written only while no result is outstanding.
module rgb_led_chain_serializer_top #(
    parameter int TICK_COUNTER_WIDTH = 16,
    parameter int BITS_PER_LED       = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // [7:0] rx_byte
    input  logic [1:0]                           s_tuser,  // [1:0] kind
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // [0] line_level, [1] power_enable_n
    // config write port
    input  logic                                 cfg_we,
    input  logic [rlcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rlcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import rlcs_pkg::*;

    cfg_t    cfg_reg;
    logic    req_accept;
    result_t result;
    logic    m_tvalid_reg;
    result_t m_result_reg;

    // the output register frees up in the same cycle the consumer takes it
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign req_accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.led_count        <= LED_COUNT_RESET;
            cfg_reg.bit_period_ticks <= BIT_PERIOD_RESET;
            cfg_reg.one_high_ticks   <= ONE_HIGH_RESET;
            cfg_reg.zero_high_ticks  <= ZERO_HIGH_RESET;
            cfg_reg.latch_gap_ticks  <= LATCH_GAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LED_COUNT:  cfg_reg.led_count        <= cfg_wdata[7:0];
                CFG_BIT_PERIOD: cfg_reg.bit_period_ticks <= cfg_wdata;
                CFG_ONE_HIGH:   cfg_reg.one_high_ticks   <= cfg_wdata;
                CFG_ZERO_HIGH:  cfg_reg.zero_high_ticks  <= cfg_wdata;
                CFG_LATCH_GAP:  cfg_reg.latch_gap_ticks  <= cfg_wdata;
                default: begin
                    // indexes past the last register are dropped
                end
            endcase
        end
    end

    // state update and next result, one request per clock while no result waits unread
    rlcs_engine #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH),
        .BITS_PER_LED       (BITS_PER_LED)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_accept  (req_accept),
        .req_kind    (kind_t'(s_tuser)),
        .req_rx_byte (s_tdata),
        .cfg         (cfg_reg),
        .result      (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (req_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_result_reg.power_enable_n, m_result_reg.line_level};

    // an accepted request always leaves a result behind
    `RLCS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, req_accept, m_tvalid)
    // an empty output register never holds back a request
    `RLCS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid_reg, s_tready)
    // the line only goes high while the lamp power is enabled
    `RLCS_ASSERT_NOW(a_high_needs_power, aclk, aresetn, m_tvalid && m_tdata[0], !m_tdata[1])

endmodule

/* test/tb_top.sv */
// self-checking bench for rgb_led_chain_serializer_top: directed table, then random requests
// depends on rlcs_pkg and the rgb_led_chain_serializer_top rtl; the line model is built in
module tb_top;
    import rlcs_pkg::*;

    // kind code that the block must ignore
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DIRECTED_ROWS   = 24;

    // one row of the directed table; checked rows carry their result literally
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx;
        logic       checked;
        logic       power_enable_n;
        logic       line_level;
    } directed_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic [1:0]             s_tuser = KIND_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_LED_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // run control shared by the processes
    bit quiet = 1'b0;
    bit hold_off_req = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    // line levels still owed by the block, oldest first
    result_t expected_line_q[$];

    // model of the chain driver: colour, lamp and frame timing
    cfg_t        chain_cfg;
    logic [7:0]  red_lvl, grn_lvl, blu_lvl;
    slot_t       byte_slot;
    logic        lamp_lit;
    logic [7:0]  led_pos;
    logic [4:0]  bit_pos;
    logic [15:0] tick_cnt;
    logic        in_gap;
    logic        frame_on;
    logic [23:0] shift_word;

    rgb_led_chain_serializer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // the current bit or gap is over once the counter reaches its span (zero acts as one)
    function automatic bit span_over(input logic [15:0] span);
        return (tick_cnt == 16'hFFFF) || (int'(tick_cnt) + 1 >= ((span == 16'd0) ? 1 : int'(span)));
    endfunction

    // next led word, sent green, red, blue msb first
    task automatic load_shift();
        shift_word = {grn_lvl, red_lvl, blu_lvl};
    endtask

    // applies one request to the model and gives the line and power state after it
    task automatic predict_line(input logic [1:0] kind, input logic [7:0] rx, output result_t res);
        logic [15:0] high_ticks;
        case (kind)
            KIND_TICK: begin
                if (frame_on) begin
                    if (in_gap) begin
                        if (span_over(chain_cfg.latch_gap_ticks)) begin
                            in_gap = 1'b0;
                            frame_on = 1'b0;
                            tick_cnt = '0;
                        end else begin
                            tick_cnt++;
                        end
                    end else if (!span_over(chain_cfg.bit_period_ticks)) begin
                        tick_cnt++;
                    end else begin
                        tick_cnt = '0;
                        if (bit_pos < 5'd23) begin
                            bit_pos++;
                            shift_word = shift_word << 1;
                        end else begin
                            bit_pos = '0;
                            // a led count of zero still sends one led
                            if (int'(led_pos) + 1 < ((chain_cfg.led_count == 8'd0) ? 1
                                                     : int'(chain_cfg.led_count))) begin
                                led_pos++;
                                load_shift();
                            end else begin
                                led_pos = '0;
                                in_gap = 1'b1;
                            end
                        end
                    end
                end else if (lamp_lit) begin
                    // the starting tick already shows the first tick of the first bit
                    frame_on = 1'b1;
                    in_gap = 1'b0;
                    led_pos = '0;
                    bit_pos = '0;
                    tick_cnt = '0;
                    load_shift();
                end
            end
            KIND_BYTE: begin
                case (byte_slot)
                    SLOT_RED: begin
                        red_lvl = rx;
                        byte_slot = SLOT_GREEN;
                    end
                    SLOT_GREEN: begin
                        grn_lvl = rx;
                        byte_slot = SLOT_BLUE;
                    end
                    SLOT_BLUE: begin
                        blu_lvl = rx;
                        byte_slot = SLOT_SKIP;
                    end
                    default: begin
                        byte_slot = SLOT_RED;
                    end
                endcase
            end
            KIND_TOGGLE: begin
                lamp_lit = !lamp_lit;
            end
            default: begin
            end
        endcase
        high_ticks = shift_word[23] ? chain_cfg.one_high_ticks : chain_cfg.zero_high_ticks;
        res.line_level = frame_on && !in_gap && (tick_cnt < high_ticks);
        res.power_enable_n = !(lamp_lit || frame_on);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s got %0d want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // offers one request, with an occasional idle burst first, and books its result
    task automatic send_request(input logic [1:0] kind, input logic [7:0] rx,
                                input logic checked, input result_t literal);
        result_t want;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_line(kind, rx, want);
        expected_line_q.push_back(checked ? literal : want);
    endtask

    // random traffic: mostly ticks with the lamp kept on, colour byte sequences, some noise
    task automatic run_random(input int count);
        int sent;
        int pick;
        int k;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < (lamp_lit ? 1 : 20)) begin
                send_request(KIND_TOGGLE, 8'($urandom), 1'b0, '0);
                sent++;
            end else if (pick < 6) begin
                // full colour sequence: red, green, blue and the dropped byte
                for (k = 0; k < 4; k++) begin
                    send_request(KIND_BYTE, 8'($urandom), 1'b0, '0);
                end
                sent += 4;
            end else if (pick < 9) begin
                send_request(KIND_UNKNOWN, 8'($urandom), 1'b0, '0);
                sent++;
            end else if (pick < 16) begin
                send_request(KIND_BYTE, 8'($urandom), 1'b0, '0);
                sent++;
            end else begin
                send_request(KIND_TICK, 8'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // stop offering and let every owed result come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_line_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_LED_COUNT:  chain_cfg.led_count = val[7:0];
            CFG_BIT_PERIOD: chain_cfg.bit_period_ticks = val;
            CFG_ONE_HIGH:   chain_cfg.one_high_ticks = val;
            CFG_ZERO_HIGH:  chain_cfg.zero_high_ticks = val;
            default:        chain_cfg.latch_gap_ticks = val;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_LED_COUNT, {8'h00, c.led_count});
        write_reg(CFG_BIT_PERIOD, c.bit_period_ticks);
        write_reg(CFG_ONE_HIGH, c.one_high_ticks);
        write_reg(CFG_ZERO_HIGH, c.zero_high_ticks);
        write_reg(CFG_LATCH_GAP, c.latch_gap_ticks);
    endtask

    // result side: random stall bursts, and one long hold-off when asked for
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // the block fills up and must push back on the request side
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare every returned result with the oldest owed one
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_line_q.size() == 0) begin
                report_mismatch("unexpected result, line_level", int'(m_tdata[0]), -1);
            end else begin
                want = expected_line_q.pop_front();
                if (m_tdata[0] !== want.line_level)
                    report_mismatch("line_level", int'(m_tdata[0]), int'(want.line_level));
                if (m_tdata[1] !== want.power_enable_n)
                    report_mismatch("power_enable_n", int'(m_tdata[1]),
                                    int'(want.power_enable_n));
            end
            results_seen++;
        end
    end

    // watchdog: too long without any handshake on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_led_chain_serializer_top: mismatch");
                $finish;
            end
        end
    end

    // directed table: colour byte cycle, lamp toggles, frame start and toggles mid-frame
    localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{KIND_TICK,    8'h00, 1'b1, 1'b1, 1'b0},  // lamp off after reset: idle line
        '{KIND_UNKNOWN, 8'hFF, 1'b1, 1'b1, 1'b0},  // unknown kind is ignored
        '{KIND_BYTE,    8'h00, 1'b1, 1'b1, 1'b0},  // red
        '{KIND_BYTE,    8'hFF, 1'b1, 1'b1, 1'b0},  // green
        '{KIND_BYTE,    8'h80, 1'b1, 1'b1, 1'b0},  // blue
        '{KIND_BYTE,    8'h01, 1'b1, 1'b1, 1'b0},  // dropped byte, cycle restarts
        '{KIND_TOGGLE,  8'h00, 1'b1, 1'b0, 1'b0},  // lamp on, no frame yet
        '{KIND_TICK,    8'h00, 1'b1, 1'b0, 1'b1},  // frame starts on a one bit
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_BYTE,    8'h7F, 1'b0, 1'b0, 1'b0},  // colour change mid-frame
        '{KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TOGGLE,  8'h00, 1'b0, 1'b0, 1'b0},  // off mid-frame, frame carries on
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TOGGLE,  8'h00, 1'b0, 1'b0, 1'b0},  // back on
        '{KIND_BYTE,    8'hAA, 1'b0, 1'b0, 1'b0},
        '{KIND_BYTE,    8'h55, 1'b0, 1'b0, 1'b0},
        '{KIND_BYTE,    8'hFF, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0},
        '{KIND_TICK,    8'h00, 1'b0, 1'b0, 1'b0}
    };

    initial begin : stimulus
        int i;
        result_t literal;
        // model state after reset
        chain_cfg = '{LED_COUNT_RESET, BIT_PERIOD_RESET, ONE_HIGH_RESET, ZERO_HIGH_RESET,
                      LATCH_GAP_RESET};
        red_lvl = RED_RESET;
        grn_lvl = GREEN_RESET;
        blu_lvl = BLUE_RESET;
        byte_slot = SLOT_RED;
        lamp_lit = 1'b0;
        led_pos = '0;
        bit_pos = '0;
        tick_cnt = '0;
        in_gap = 1'b0;
        frame_on = 1'b0;
        shift_word = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            literal.line_level = DIRECTED[i].line_level;
            literal.power_enable_n = DIRECTED[i].power_enable_n;
            send_request(DIRECTED[i].kind, DIRECTED[i].rx, DIRECTED[i].checked, literal);
        end
        // reset settings: long frames, only the start of one is seen
        run_random(120);
        drain();

        // one short led, tight timing, with the long result hold-off
        apply_settings('{8'd1, 16'd3, 16'd2, 16'd1, 16'd4});
        hold_off_req = 1'b1;
        run_random(220);
        drain();

        // zero bit period and zero latch gap act as one; one bits high for the whole bit
        apply_settings('{8'd2, 16'd0, 16'hFFFF, 16'd1, 16'd0});
        run_random(150);
        drain();

        // zero led count acts as one; high time beyond the period
        apply_settings('{8'd0, 16'd5, 16'd7, 16'd2, 16'd1});
        run_random(150);
        drain();

        // largest values everywhere but the one-bit high time
        apply_settings('{8'd255, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF});
        run_random(60);
        drain();

        // closing stretch: no idling on either side
        quiet = 1'b1;
        apply_settings('{8'd3, 16'd4, 16'd3, 16'd1, 16'd2});
        run_random(200);
        drain();
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_line_q.size() == 0) begin
            $display("rgb_led_chain_serializer_top: match");
        end else begin
            $display("rgb_led_chain_serializer_top: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rlcs_pkg.sv
rtl/rlcs_engine.sv
rtl/rgb_led_chain_serializer_top.sv
test/tb_top.sv
